[hdl/tsm_pkg.sv]
// tsm_pkg: shared types, constants and the exp2 fraction table of the softmax sampler.
// Depends on nothing; imported by every module of the sampler.
`default_nettype none
package tsm_pkg;

    localparam int MAX_VOCAB = 32768;
    localparam int IDX_W     = 15;            // address width of the logit store
    localparam int CNT_W     = 16;            // holds 0..MAX_VOCAB
    localparam int EXP_BITS  = 8;
    localparam int EXP_TABLE_SIZE = 1 << EXP_BITS;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [12:0] CLAMP_Q8  = 13'd4096;
    localparam logic [15:0] TEMP_RESET = 16'd256;

    typedef logic [15:0] exp_tab_t [EXP_TABLE_SIZE];

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [15:0]      maxv;
        logic [15:0]      rnd;
    } job_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [15:0]      data;
    } mem_wr_t;

    // round(65536 * 2^(-k/EXP_TABLE_SIZE)) via a 13-term Q0.32 series of e^-x
    function automatic exp_tab_t exp_table_build();
        exp_tab_t    tab;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
            a    = (64'(k) * LN2_Q32) >> EXP_BITS;
            term = 64'd1 << 32;
            pos  = term;
            neg  = 64'd0;
            for (int n = 1; n <= 13; n++) begin
                term = ((term * a) >> 32) / 64'(n);
                if (n % 2 == 1)
                    neg = neg + term;
                else
                    pos = pos + term;
            end
            r = (pos > neg) ? pos - neg : 64'd0;
            r = (r + 64'h8000) >> 16;
            tab[k] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = exp_table_build();

endpackage
`default_nettype wire

[hdl/tsm_front.sv]
// tsm_front: accepts logit transfers, tracks count and maximum, writes the logit store,
// and posts a job when the last logit arrives. Depends on tsm_pkg.
`default_nettype none
module tsm_front
    import tsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] logit,
    input  wire logic        is_last,
    input  wire logic [15:0] random_fraction,
    input  wire logic        hold,
    output mem_wr_t          mem_wr,
    output logic             job_push,
    output job_t             job
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      max_reg, max_next;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_upd;
    logic [15:0]      max_upd;

    assign in_stall = hold;
    assign accept   = in_valid & ~hold;
    assign room     = (count_reg < CNT_W'(MAX_VOCAB));

    always_comb
    begin
        count_upd = count_reg;
        max_upd   = max_reg;
        if (room)
        begin
            count_upd = count_reg + 1'b1;
            if ($signed(logit) > $signed(max_reg))
                max_upd = logit;
        end
    end

    assign mem_wr.en   = accept & room;
    assign mem_wr.addr = count_reg[IDX_W-1:0];
    assign mem_wr.data = logit;

    assign job_push  = accept & is_last;
    assign job.count = count_upd;
    assign job.maxv  = max_upd;
    assign job.rnd   = random_fraction;

    always_comb
    begin
        count_next = count_reg;
        max_next   = max_reg;
        if (accept)
        begin
            if (is_last)
            begin
                count_next = '0;
                max_next   = 16'h8000;
            end
            else
            begin
                count_next = count_upd;
                max_next   = max_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= 16'h8000;
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
        end
    end

endmodule
`default_nettype wire

[hdl/tsm_jobq.sv]
// tsm_jobq: two-entry queue of sampling jobs between front and back.
// Depends on tsm_pkg.
`default_nettype none
module tsm_jobq
    import tsm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output logic      nonempty,
    output job_t      head
);

    job_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign nonempty = (cnt_reg != 2'd0);
    assign head     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2 || pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("job queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("job queue count out of range");
`endif

endmodule
`default_nettype wire

[hdl/tsm_back.sv]
// tsm_back: logit store plus the sequencer that runs the weight-sum pass and the
// cumulative search pass, with a shared divider, multiplier and exp2 table. Depends on tsm_pkg.
`default_nettype none
module tsm_back
    import tsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  mem_wr_t          mem_wr,
    input  wire logic [15:0] temperature,
    input  wire logic        job_valid,
    input  job_t             job_in,
    output logic             job_pop,
    output logic             busy,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [IDX_W-1:0] token_index
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_PREP = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_WGT  = 9'b000100000,
        S_ACC  = 9'b001000000,
        S_TGT  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    logic [15:0] mem [MAX_VOCAB];
    logic [15:0] rd_data_reg;

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic             pass2_reg, pass2_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [15:0]      rem_reg, rem_next;
    logic [11:0]      quo_reg, quo_next;
    logic [11:0]      nlo_reg, nlo_next;
    logic [3:0]       bit_reg, bit_next;
    logic [12:0]      m_reg, m_next;
    logic [29:0]      y_reg, y_next;
    logic [15:0]      w_reg, w_next;
    logic [31:0]      sum_reg, sum_next;
    logic [31:0]      cum_reg, cum_next;
    logic [47:0]      tgt_reg, tgt_next;
    logic [IDX_W-1:0] res_reg, res_next;
    logic             ov_reg, ov_next;
    logic [IDX_W-1:0] oi_reg, oi_next;

    logic [15:0] t_eff;
    logic [16:0] diff;
    logic [16:0] trial;
    logic        qbit;
    logic [21:0] yq;
    logic [31:0] cum_add;
    logic        last_elem;

    // logit store: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            mem[mem_wr.addr] <= mem_wr.data;
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    assign t_eff     = (temperature == 16'd0) ? 16'd1 : temperature;
    assign diff      = 17'($signed(job_reg.maxv) - $signed(rd_data_reg));
    assign trial     = {rem_reg, nlo_reg[11]};
    assign qbit      = (trial >= {1'b0, t_eff});
    assign yq        = y_reg[29:8];
    assign cum_add   = cum_reg + {16'd0, w_reg};
    assign last_elem = ((idx_reg + 1'b1) == job_reg.count);

    assign busy        = (state_reg != S_IDLE);
    assign job_pop     = (state_reg == S_IDLE) & job_valid;
    assign out_valid   = ov_reg;
    assign token_index = oi_reg;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        pass2_next = pass2_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        nlo_next   = nlo_reg;
        bit_next   = bit_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        w_next     = w_reg;
        sum_next   = sum_reg;
        cum_next   = cum_reg;
        tgt_next   = tgt_reg;
        res_next   = res_reg;
        ov_next    = ov_reg & out_stall;
        oi_next    = oi_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job_in;
                    idx_next   = '0;
                    pass2_next = 1'b0;
                    sum_next   = '0;
                    cum_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_PREP;
            S_PREP:
            begin
                // d/T saturates at 16.0 exactly when diff >= 16*T
                if ({4'd0, diff[15:0]} >= {t_eff, 4'd0})
                begin
                    m_next     = CLAMP_Q8;
                    state_next = S_MUL;
                end
                else
                begin
                    rem_next   = {4'd0, diff[15:4]};
                    nlo_next   = {diff[3:0], 8'd0};
                    quo_next   = '0;
                    bit_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = qbit ? 16'(trial - {1'b0, t_eff}) : trial[15:0];
                quo_next = {quo_reg[10:0], qbit};
                nlo_next = {nlo_reg[10:0], 1'b0};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 4'd11)
                begin
                    m_next     = {1'b0, quo_reg[10:0], qbit};
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                y_next     = 30'(m_reg * LOG2E_Q16);
                state_next = S_WGT;
            end
            S_WGT:
            begin
                w_next     = EXP_TABLE[yq[15:16-EXP_BITS]] >> yq[21:16];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!pass2_reg)
                begin
                    sum_next = sum_reg + {16'd0, w_reg};
                    if (last_elem)
                        state_next = S_TGT;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    cum_next = cum_add;
                    if (tgt_reg <= {cum_add, 16'd0})
                    begin
                        res_next   = idx_reg[IDX_W-1:0];
                        state_next = S_DONE;
                    end
                    else if (last_elem)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_TGT:
            begin
                tgt_next   = 48'(job_reg.rnd * sum_reg);
                idx_next   = '0;
                pass2_next = 1'b1;
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oi_next    = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        pass2_reg <= pass2_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        nlo_reg   <= nlo_next;
        bit_reg   <= bit_next;
        m_reg     <= m_next;
        y_reg     <= y_next;
        w_reg     <= w_next;
        sum_reg   <= sum_next;
        cum_reg   <= cum_next;
        tgt_reg   <= tgt_next;
        res_reg   <= res_next;
        oi_reg    <= oi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
`default_nettype wire

[hdl/temperature_softmax_sampler_top.sv]
// Path: the last logit's transfer posts a job to the queue; the sequencer then runs every one
// of the N loaded logits through the sum pass and the first K = index + 1 through the search
// pass, each element going READ, PREP, the 12-step divider (skipped when the scaled difference
// saturates), MUL, WGT and ACC. Loading takes one logit per cycle while in_stall is low.
// Throughput: one vector at a time; input stalls while a vector is being sampled.
// Reset (rst_n, async, active low): temperature = 1.0, empty vector, max = most negative.
`default_nettype none
module temperature_softmax_sampler_top
    import tsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] logit,
    input  wire logic        is_last,
    input  wire logic [15:0] random_fraction,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [14:0]      token_index
);

    logic [15:0] temp_reg;
    logic        hold;
    mem_wr_t     mem_wr;
    logic        job_push;
    job_t        job_new;
    logic        job_pop;
    logic        q_nonempty;
    job_t        job_head;
    logic        back_busy;

    // temperature register, to be written only between vectors; the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            temp_reg <= TEMP_RESET;
        else if (cfg_we)
            temp_reg <= cfg_wdata;
    end

    // front may not touch the store while a job is queued or being sampled
    assign hold = q_nonempty | back_busy;

    tsm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .logit           (logit),
        .is_last         (is_last),
        .random_fraction (random_fraction),
        .hold            (hold),
        .mem_wr          (mem_wr),
        .job_push        (job_push),
        .job             (job_new)
    );

    tsm_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_new),
        .pop      (job_pop),
        .nonempty (q_nonempty),
        .head     (job_head)
    );

    tsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mem_wr      (mem_wr),
        .temperature (temp_reg),
        .job_valid   (q_nonempty),
        .job_in      (job_head),
        .job_pop     (job_pop),
        .busy        (back_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_index (token_index)
    );

endmodule
`default_nettype wire

[tb/tb_temperature_softmax_sampler_top.sv]
// Testbench for temperature_softmax_sampler_top: directed and random logit vectors, checked
// against an in-bench predictor of the softmax draw. Depends on tsm_pkg and the top level.
`timescale 1ns / 1ps
module tb_temperature_softmax_sampler_top;
    import tsm_pkg::*;

    localparam int  VOCAB_LIMIT = MAX_VOCAB;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam int  DRAIN_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] logit;
    logic        is_last;
    logic [15:0] random_fraction;
    logic        out_valid;
    logic        out_stall;
    logic [14:0] token_index;

    temperature_softmax_sampler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .logit          (logit),
        .is_last        (is_last),
        .random_fraction(random_fraction),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_index    (token_index)
    );

    // 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------- predictor state ----------------
    logic [15:0]       pow2_frac [EXP_TABLE_SIZE];  // 2^(-k/256) in Q0.16
    logic [15:0]       temp_reg;                    // mirror of the temperature register
    logic signed [15:0] vec_logits [$];             // logits stored in the current vector
    logic signed [15:0] vec_max;
    logic [14:0]       token_q [$];                 // expected sampled indexes, oldest first

    int  mismatches;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  rcv_hold;
    longint cycles;

    // Build the fraction table: 13-term Taylor series of e^-x in Q0.32, truncated products,
    // rounded half up to Q0.16.
    function automatic void build_pow2_frac();
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        for (int k = 0; k < EXP_TABLE_SIZE; k++)
        begin
            a    = (64'(k) * 64'd2977044472) / 64'(EXP_TABLE_SIZE);
            term = 64'd1 << 32;
            pos  = term;
            neg  = 0;
            for (int n = 1; n <= 13; n++)
            begin
                term = ((term * a) >> 32) / 64'(n);
                if (n & 1)
                    neg += term;
                else
                    pos += term;
            end
            r = (pos > neg) ? pos - neg : 64'd0;
            r = (r + 64'h8000) >> 16;
            pow2_frac[k] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        end
    endfunction

    // Unnormalized weight exp((logit - max)/T) in Q0.16.
    function automatic logic [31:0] softmax_weight(logic signed [15:0] val,
                                                   logic signed [15:0] mx,
                                                   logic [15:0] t);
        logic [31:0] diff;
        logic [31:0] m;
        logic [63:0] y;
        logic [31:0] sh;
        logic [31:0] k;
        diff = 32'($signed(mx) - $signed(val));
        m    = (diff << 8) / 32'(t);
        if (m > 32'd4096)
            m = 32'd4096;
        y  = (64'(m) * 64'd94548) >> 8;
        sh = 32'(y >> 16);
        k  = 32'(((y & 64'hFFFF) * 64'(EXP_TABLE_SIZE)) >> 16);
        if (k >= EXP_TABLE_SIZE)
            k = EXP_TABLE_SIZE - 1;
        if (sh >= 32)
            return 32'd0;
        return 32'(pow2_frac[k]) >> sh;
    endfunction

    // Absorb one accepted transfer; on the last logit push the sampled index.
    function automatic void absorb_logit(logic signed [15:0] val, bit last, logic [15:0] rnd);
        logic [15:0] t;
        logic [31:0] total;
        logic [63:0] cum;
        logic [14:0] pick;
        if (vec_logits.size() < VOCAB_LIMIT)
        begin
            vec_logits.push_back(val);
            if (val > vec_max)
                vec_max = val;
        end
        if (!last)
            return;
        t = (temp_reg == 0) ? 16'd1 : temp_reg;
        total = 0;
        foreach (vec_logits[i])
            total += softmax_weight(vec_logits[i], vec_max, t);
        cum  = 0;
        pick = 0;
        foreach (vec_logits[i])
        begin
            cum += softmax_weight(vec_logits[i], vec_max, t);
            if (64'(rnd) * 64'(total) <= (cum << 16))
            begin
                pick = 15'(i);
                break;
            end
        end
        token_q.push_back(pick);
        vec_logits.delete();
        vec_max = -16'sd32768;
    endfunction

    // ---------------- sender ----------------
    task automatic send_logit(logic signed [15:0] val, bit last, logic [15:0] rnd);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        logit           <= val;
        is_last         <= last;
        random_fraction <= rnd;
        do
            @(posedge clk);
        while (in_stall);
        absorb_logit(val, last, rnd);
    endtask

    // Only called with no vector open; waits until every sampled index has been returned.
    task automatic write_temperature(logic [15:0] t);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (token_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_we    <= 1'b0;
        temp_reg   = t;
    endtask

    // ---------------- receiver / checker ----------------
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (token_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token_index transfer: %0d", token_index);
            end
            else
            begin
                logic [14:0] exp_idx;
                exp_idx = token_q.pop_front();
                if (token_index !== exp_idx)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token_index mismatch: expected %0d, got %0d",
                                 exp_idx, token_index);
                end
            end
        end
        out_stall <= rcv_hold || ($urandom_range(99) < rcv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic send_vector(int len, logic signed [15:0] base, int spread, logic [15:0] rnd);
        logic signed [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            if (spread < 0)
                v = 16'($urandom);
            else
                v = base + 16'($signed($urandom_range(2 * spread)) - spread);
            send_logit(v, i == len - 1, rnd);
        end
    endtask

    // extremes of every field and the named special cases at T = 1.0
    task automatic test_directed();
        send_logit(-16'sd32768, 1'b1, 16'hFFFF);      // single logit, most negative
        send_logit(16'sd32767, 1'b0, 16'h0);
        send_logit(-16'sd32768, 1'b0, 16'h0);
        send_logit(16'sd0, 1'b1, 16'h0);              // zero random fraction
        send_logit(16'sd100, 1'b0, 16'h0);
        send_logit(16'sd100, 1'b0, 16'h0);
        send_logit(16'sd100, 1'b0, 16'h0);
        send_logit(16'sd100, 1'b1, 16'h8000);         // equal logits
        send_logit(-16'sd5, 1'b0, 16'h0);
        send_logit(16'sd0, 1'b0, 16'h0);
        send_logit(16'sd300, 1'b1, 16'hFFFF);         // largest fraction
        send_logit(16'sd32767, 1'b0, 16'h1234);
        send_logit(16'sd32767, 1'b1, 16'hFFFF);
    endtask

    // zero, smallest, largest and mid temperatures
    task automatic test_temperatures();
        logic [15:0] temps [5];
        temps = '{16'd0, 16'd1, 16'd65535, 16'd64, 16'd1000};
        foreach (temps[j])
        begin
            write_temperature(temps[j]);
            send_vector(6, 16'sd0, 800, 16'($urandom));
            send_vector(4, 16'sd0, -1, 16'hFFFF);
            send_vector(5, 16'sd200, 20, 16'h0001);
        end
    endtask

    // More than MAX_VOCAB logits: the tail is dropped, a larger dropped logit must not
    // move the max, and the dropped last logit still triggers the draw. T=1 keeps every
    // element but the maximum on the fast saturated path.
    task automatic test_overflow();
        write_temperature(16'd1);
        snd_idle_pct = 0;
        send_logit(16'sd1000, 1'b0, 16'h0);
        for (int i = 1; i < VOCAB_LIMIT; i++)
            send_logit(-16'sd30000 + 16'($urandom_range(1000)), 1'b0, 16'h0);
        send_logit(16'sd32767, 1'b0, 16'h0);
        send_logit(16'sd32000, 1'b1, 16'($urandom));
    endtask

    // well-formed vectors with random content, random temperature per phase
    task automatic test_random(int n_items);
        int sent;
        int len;
        int kind;
        logic [15:0] rnd;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
                write_temperature($urandom_range(3) == 0 ? 16'($urandom_range(4))
                                                         : 16'($urandom));
            len  = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            kind = $urandom_range(3);
            case ($urandom_range(7))
                0: rnd = 16'h0;
                1: rnd = 16'hFFFF;
                default: rnd = 16'($urandom);
            endcase
            case (kind)
                0: send_vector(len, 16'sd0, -1, rnd);
                1: send_vector(len, 16'($urandom), 30, rnd);
                2: send_vector(len, 16'($urandom), 2000, rnd);
                default: send_vector(len, 16'sd0, 400, rnd);
            endcase
            sent += len;
        end
    endtask

    // Receiver holds off for a long stretch while vectors keep coming, so the block
    // fills and stalls its input; then the sender waits for every result.
    task automatic test_backpressure();
        write_temperature(16'd256);
        fork
            begin
                rcv_hold = 1'b1;
                repeat (600) @(posedge clk);
                rcv_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 6; i++)
            send_vector(5, 16'sd0, 300, 16'($urandom));
        in_valid <= 1'b0;
        @(posedge clk);
        wait (token_q.size() == 0);
        send_vector(8, 16'sd0, 500, 16'($urandom));
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        logit           = '0;
        is_last         = 1'b0;
        random_fraction = '0;
        out_stall       = 1'b0;
        rcv_hold        = 1'b0;
        mismatches      = 0;
        cycles          = 0;
        temp_reg        = TEMP_RESET;
        vec_max         = -16'sd32768;
        build_pow2_frac();
        snd_idle_pct    = 10;
        rcv_idle_pct    = 49;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_temperatures();
        test_random(700);
        snd_idle_pct = 49;
        rcv_idle_pct = 10;
        test_random(700);
        test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(600);
        test_overflow();

        in_valid <= 1'b0;
        @(posedge clk);
        wait (token_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && token_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
